### rtl/pcf_pkg.sv
package pcf_pkg;

  // field widths of the stream items
  localparam int CMD_W    = 2;
  localparam int CH_W     = 4;
  localparam int RAW_W    = 16;
  localparam int PRES_W   = 32;
  localparam int GAIN_W   = 26;
  localparam int ALPHA_W  = 24;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 40;

  // defaults for the top level parameters
  localparam int CHANNELS_DEF    = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // wide signed working width for saturating sums
  localparam int SAT_W = 40;
  localparam logic signed [SAT_W-1:0] SAT_HI = 40'sh00_7FFF_FFFF;
  localparam logic signed [SAT_W-1:0] SAT_LO = 40'shFF_8000_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_TARE   = 2'd2,
    CMD_SETCAL = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCALE,
    ST_DIFF,
    ST_MUL2,
    ST_UPD
  } state_t;

  // per-channel calibration row
  typedef struct packed {
    logic [ALPHA_W-1:0]       alpha;
    logic signed [PRES_W-1:0] offset;
    logic [GAIN_W-1:0]        gain;
  } cal_t;

  // strobes from the sequencer to the datapath
  typedef struct packed {
    logic take;
    logic mul;
    logic scale;
    logic diff;
    logic mul2;
    logic filt_we;
    logic cal_we;
    logic out_load;
  } ctl_t;

  function automatic logic signed [PRES_W-1:0] sat_s32(input logic signed [SAT_W-1:0] v);
    logic signed [PRES_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[PRES_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[PRES_W-1:0];
    end else begin
      r = v[PRES_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/pcf_ram.sv
module pcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/pcf_ctrl.sv
module pcf_ctrl import pcf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  cmd_t cmd_r,
  input  logic ch_ok_r,
  input  logic out_free,
  output logic in_tready,
  output ctl_t ctl
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        unique case (cmd_r)
          CMD_SAMPLE: state_nxt = ch_ok_r ? ST_SCALE : ST_IDLE;
          CMD_READ:   state_nxt = out_free ? ST_IDLE : ST_LOOK;
          CMD_TARE:   state_nxt = ST_IDLE;
          CMD_SETCAL: state_nxt = ST_IDLE;
          default:    state_nxt = ST_IDLE;
        endcase
      end
      ST_SCALE: state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // strobes
  always_comb begin
    in_tready    = (state_r == ST_IDLE);
    ctl          = '0;
    ctl.take     = (state_r == ST_IDLE) && in_tvalid;
    ctl.mul      = (state_r == ST_LOOK) && (cmd_r == CMD_SAMPLE);
    ctl.cal_we   = (state_r == ST_LOOK) && ch_ok_r
                   && ((cmd_r == CMD_TARE) || (cmd_r == CMD_SETCAL));
    ctl.out_load = (state_r == ST_LOOK) && (cmd_r == CMD_READ) && out_free;
    ctl.scale    = (state_r == ST_SCALE);
    ctl.diff     = (state_r == ST_DIFF);
    ctl.mul2     = (state_r == ST_MUL2);
    ctl.filt_we  = (state_r == ST_UPD);
  end

endmodule

### rtl/pcf_ema.sv
module pcf_ema import pcf_pkg::*; #(
  parameter int CNT_W = 16
) (
  input  logic                     clk,
  input  ctl_t                     ctl,
  input  logic [CNT_W-1:0]         cnt,
  input  logic [GAIN_W-1:0]        gain,
  input  logic signed [PRES_W-1:0] offset,
  input  logic [ALPHA_W-1:0]       alpha,
  input  logic signed [PRES_W-1:0] y_cur,
  output logic signed [PRES_W-1:0] y_new
);

  localparam int PROD_W = CNT_W + GAIN_W;
  localparam int SCL_W  = PROD_W - 11;
  localparam int MAG_W  = PRES_W + 1;
  localparam int P_W    = MAG_W + ALPHA_W;
  localparam int Q_W    = P_W - 23;

  logic [PROD_W-1:0]        prod_r;
  logic signed [PRES_W-1:0] x_r;
  logic [MAG_W-1:0]         mag_r;
  logic                     neg_r;
  logic [P_W-1:0]           p_r;

  logic [PROD_W:0]          rsum;
  logic [SCL_W-1:0]         scaled;
  logic signed [SAT_W-1:0]  scl_e;
  logic signed [SAT_W-1:0]  scl_cap;
  logic signed [SAT_W-1:0]  dif;
  logic signed [SAT_W-1:0]  dif_abs;
  logic [P_W:0]             psum;
  logic [Q_W-1:0]           q;
  logic signed [SAT_W-1:0]  qe;
  logic signed [SAT_W-1:0]  qs;

  // count times gain, exact Q.24
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= PROD_W'(cnt) * PROD_W'(gain);
    end
  end

  // round to Q.12, cap, add offset
  always_comb begin
    rsum    = {1'b0, prod_r} + (PROD_W + 1)'(2048);
    scaled  = rsum[PROD_W:12];
    scl_e   = SAT_W'(scaled);
    scl_cap = (scl_e > SAT_HI) ? SAT_HI : scl_e;
  end

  always_ff @(posedge clk) begin
    if (ctl.scale) begin
      x_r <= sat_s32(scl_cap + SAT_W'(offset));
    end
  end

  // distance to the filtered value, as sign and magnitude
  always_comb begin
    dif     = SAT_W'(x_r) - SAT_W'(y_cur);
    dif_abs = dif[SAT_W-1] ? -dif : dif;
  end

  always_ff @(posedge clk) begin
    if (ctl.diff) begin
      mag_r <= dif_abs[MAG_W-1:0];
      neg_r <= dif[SAT_W-1];
    end
  end

  // magnitude times alpha
  always_ff @(posedge clk) begin
    if (ctl.mul2) begin
      p_r <= P_W'(mag_r) * P_W'(alpha);
    end
  end

  // round half away from zero, restore sign, saturating update
  always_comb begin
    psum  = {1'b0, p_r} + (P_W + 1)'(24'h80_0000);
    q     = psum[P_W:24];
    qe    = SAT_W'(q);
    qs    = neg_r ? -qe : qe;
    y_new = sat_s32(SAT_W'(y_cur) + qs);
  end

endmodule

### rtl/pressure_channel_calibrate_filter.sv
// read: the item is registered on transfer and the look state loads the output register
// throughput: one item at a time; a sample runs look, scale, difference, multiply and update
//   (two registered multiplies plus scale, difference and update steps around the state
//   memory), a read waits in the look state while the previous result is not taken
// reset: synchronous, active low; clears the sequencer, the output valid and the
//   per-channel valid bits, so every channel reads as zero state after reset
module pressure_channel_calibrate_filter import pcf_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // channel, raw_sample, tare_amount, gain_value, offset_value, alpha_value
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // result_channel, pressure
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = (SAMPLE_BITS < RAW_W) ? SAMPLE_BITS : RAW_W;

  // input fields
  logic [CH_W-1:0]          in_ch;
  logic [RAW_W-1:0]         in_raw;
  logic signed [PRES_W-1:0] in_tare;
  logic [GAIN_W-1:0]        in_gain;
  logic signed [PRES_W-1:0] in_off;
  logic [ALPHA_W-1:0]       in_alpha;
  logic                     in_ch_ok;

  assign in_ch    = in_tdata[3:0];
  assign in_raw   = in_tdata[19:4];
  assign in_tare  = in_tdata[51:20];
  assign in_gain  = in_tdata[77:52];
  assign in_off   = in_tdata[109:78];
  assign in_alpha = in_tdata[133:110];
  assign in_ch_ok = (32'(in_ch) < CHANNELS);

  // item held for the length of its work
  cmd_t                     cmd_r;
  logic [CH_W-1:0]          ch_r;
  logic [ADDR_W-1:0]        addr_r;
  logic                     ch_ok_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [PRES_W-1:0] tare_r;
  logic [GAIN_W-1:0]        gain_in_r;
  logic signed [PRES_W-1:0] off_in_r;
  logic [ALPHA_W-1:0]       alpha_in_r;

  logic [CHANNELS-1:0]      cal_vld_r;
  logic [CHANNELS-1:0]      filt_vld_r;

  logic                     out_tvalid_r;
  logic [CH_W-1:0]          out_ch_r;
  logic signed [PRES_W-1:0] out_pres_r;

  ctl_t                     ctl;
  logic                     out_free;
  logic [$bits(cal_t)-1:0]  cal_rd;
  logic [PRES_W-1:0]        filt_rd;
  cal_t                     cal_cur;
  cal_t                     cal_wr;
  logic signed [PRES_W-1:0] y_cur;
  logic signed [PRES_W-1:0] y_new;
  logic signed [PRES_W-1:0] off_tared;

  assign out_free = !out_tvalid_r || out_tready;

  // capture the item on transfer
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd_r      <= cmd_t'(in_tuser);
      ch_r       <= in_ch;
      addr_r     <= ADDR_W'(in_ch);
      ch_ok_r    <= in_ch_ok;
      cnt_r      <= in_raw[CNT_W-1:0];
      tare_r     <= in_tare;
      gain_in_r  <= in_gain;
      off_in_r   <= in_off;
      alpha_in_r <= in_alpha;
    end
  end

  pcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .cmd_r     (cmd_r),
    .ch_ok_r   (ch_ok_r),
    .out_free  (out_free),
    .in_tready (in_tready),
    .ctl       (ctl)
  );

  // calibration memory, read on transfer, written back on tare or set calibration
  pcf_ram #(
    .WIDTH ($bits(cal_t)),
    .DEPTH (CHANNELS)
  ) u_cal_ram (
    .clk   (clk),
    .we    (ctl.cal_we),
    .waddr (addr_r),
    .wdata (cal_wr),
    .re    (ctl.take && in_ch_ok),
    .raddr (ADDR_W'(in_ch)),
    .rdata (cal_rd)
  );

  // filtered value memory, written back at the end of a sample
  pcf_ram #(
    .WIDTH (PRES_W),
    .DEPTH (CHANNELS)
  ) u_filt_ram (
    .clk   (clk),
    .we    (ctl.filt_we),
    .waddr (addr_r),
    .wdata (y_new),
    .re    (ctl.take && in_ch_ok),
    .raddr (ADDR_W'(in_ch)),
    .rdata (filt_rd)
  );

  // never-written entries read as zero
  always_comb begin
    cal_cur = cal_vld_r[addr_r] ? cal_t'(cal_rd) : '0;
    y_cur   = filt_vld_r[addr_r] ? filt_rd : '0;
  end

  // tare and set calibration row
  always_comb begin
    off_tared = sat_s32(SAT_W'(cal_cur.offset) - SAT_W'(tare_r));
    cal_wr    = cal_cur;
    if (cmd_r == CMD_SETCAL) begin
      cal_wr.gain   = gain_in_r;
      cal_wr.offset = off_in_r;
      cal_wr.alpha  = alpha_in_r;
    end else begin
      cal_wr.offset = off_tared;
    end
  end

  pcf_ema #(
    .CNT_W (CNT_W)
  ) u_ema (
    .clk    (clk),
    .ctl    (ctl),
    .cnt    (cnt_r),
    .gain   (cal_cur.gain),
    .offset (cal_cur.offset),
    .alpha  (cal_cur.alpha),
    .y_cur  (y_cur),
    .y_new  (y_new)
  );

  // per-channel valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_vld_r  <= '0;
      filt_vld_r <= '0;
    end else begin
      if (ctl.cal_we) cal_vld_r[addr_r] <= 1'b1;
      if (ctl.filt_we) filt_vld_r[addr_r] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_ch_r   <= ch_r;
      out_pres_r <= ch_ok_r ? y_cur : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, out_pres_r, out_ch_r};

  // an accepted item holds off the next one in the following cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice in a row");

  // filter write-back only for a sample on a valid channel
  a_filt_we_sample: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.filt_we |-> (cmd_r == CMD_SAMPLE) && ch_ok_r)
    else $error("filter write without sample");

  // calibration write-back only for tare or set calibration
  a_cal_we_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.cal_we |-> (cmd_r == CMD_TARE) || (cmd_r == CMD_SETCAL))
    else $error("calibration write from wrong command");

  // a new result only follows a read
  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd_r == CMD_READ))
    else $error("result without read");

endmodule
